FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i and disabled while
// rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/i2r_pkg.sv
// ----------------------------------------------------------------------------
// i2r_pkg
// Types, letter codes and place tables for the Roman numeral speller.
// ----------------------------------------------------------------------------
package i2r_pkg;

  localparam int unsigned ValueW  = 12;
  localparam int unsigned LetterW = 7;
  localparam int unsigned PlaceW  = 4;
  localparam int unsigned NPlaces = 13;

  // ASCII codes of the numeral letters
  localparam logic [LetterW-1:0] ChNone = 7'd0;
  localparam logic [LetterW-1:0] ChI    = 7'd73;
  localparam logic [LetterW-1:0] ChV    = 7'd86;
  localparam logic [LetterW-1:0] ChX    = 7'd88;
  localparam logic [LetterW-1:0] ChL    = 7'd76;
  localparam logic [LetterW-1:0] ChC    = 7'd67;
  localparam logic [LetterW-1:0] ChD    = 7'd68;
  localparam logic [LetterW-1:0] ChM    = 7'd77;

  // Item handed from front to back
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              zero;
  } i2r_item_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SECOND
  } i2r_state_e;

  // Weight of each place, highest first
  function automatic logic [ValueW-1:0] place_weight(input logic [PlaceW-1:0] p);
    logic [ValueW-1:0] w;
    case (p)
      4'd0:    w = 12'd1000;
      4'd1:    w = 12'd900;
      4'd2:    w = 12'd500;
      4'd3:    w = 12'd400;
      4'd4:    w = 12'd100;
      4'd5:    w = 12'd90;
      4'd6:    w = 12'd50;
      4'd7:    w = 12'd40;
      4'd8:    w = 12'd10;
      4'd9:    w = 12'd9;
      4'd10:   w = 12'd5;
      4'd11:   w = 12'd4;
      default: w = 12'd1;
    endcase
    return w;
  endfunction

  // Leading letter of each place
  function automatic logic [LetterW-1:0] place_first(input logic [PlaceW-1:0] p);
    logic [LetterW-1:0] c;
    case (p)
      4'd0:    c = ChM;
      4'd1:    c = ChC;
      4'd2:    c = ChD;
      4'd3:    c = ChC;
      4'd4:    c = ChC;
      4'd5:    c = ChX;
      4'd6:    c = ChL;
      4'd7:    c = ChX;
      4'd8:    c = ChX;
      4'd9:    c = ChI;
      4'd10:   c = ChV;
      default: c = ChI;
    endcase
    return c;
  endfunction

  // Trailing letter of a subtractive pair, ChNone for single letters
  function automatic logic [LetterW-1:0] place_second(input logic [PlaceW-1:0] p);
    logic [LetterW-1:0] c;
    case (p)
      4'd1:    c = ChM;
      4'd3:    c = ChD;
      4'd5:    c = ChC;
      4'd7:    c = ChL;
      4'd9:    c = ChX;
      4'd11:   c = ChV;
      default: c = ChNone;
    endcase
    return c;
  endfunction

  // Highest place whose weight still fits into the remainder
  function automatic logic [PlaceW-1:0] place_find(input logic [ValueW-1:0] rest);
    logic [PlaceW-1:0] p;
    p = PlaceW'(NPlaces - 1);
    for (int i = NPlaces - 1; i >= 0; i--) begin
      if (rest >= place_weight(PlaceW'(i))) begin
        p = PlaceW'(i);
      end
    end
    return p;
  endfunction

endpackage

FILE: sv/i2r_front.sv
// ----------------------------------------------------------------------------
// i2r_front
// Accepts input beats, tags zero values and holds them in a short queue
// until the back end takes them.
// ----------------------------------------------------------------------------
module i2r_front #(
  parameter int unsigned Depth = 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [i2r_pkg::ValueW-1:0] value_i,
  output logic                      item_valid_o,
  output i2r_pkg::i2r_item_t        item_o,
  input  logic                      item_take_i
);
  import i2r_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  i2r_item_t         slot_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              wr_en, rd_en;
  i2r_item_t         new_item;

  // Classify the incoming value
  assign new_item.value = value_i;
  assign new_item.zero  = (value_i == '0);

  assign full         = (cnt_q == CntW'(Depth));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = slot_q[rd_ptr_q];
  assign wr_en        = push && !full;
  assign rd_en        = item_take_i && item_valid_o;

  // Advance pointers with wrap and track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the accepted beat
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

FILE: sv/i2r_back.sv
// ----------------------------------------------------------------------------
// i2r_back
// Spells one queued value letter by letter into a one-entry result register,
// largest fitting place first.
// ----------------------------------------------------------------------------
module i2r_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  input  i2r_pkg::i2r_item_t          item_i,
  output logic                        item_take_o,
  output logic                        empty,
  input  logic                        pop,
  output logic [i2r_pkg::LetterW-1:0] letter_o,
  output logic                        last_o,
  output logic                        empty_res_o
);
  import i2r_pkg::*;

  i2r_state_e          state_q, state_d;
  logic [ValueW-1:0]   rest_q, rest_d;
  logic [LetterW-1:0]  second_q, second_d;
  logic                out_valid_q, out_valid_d;
  logic [LetterW-1:0]  letter_q, letter_d;
  logic                last_q, last_d;
  logic                empty_res_q, empty_res_d;
  logic                slot_free;
  logic                emit;
  logic [PlaceW-1:0]   place;
  logic [ValueW-1:0]   rest_sub;
  logic [LetterW-1:0]  pair_letter;

  // Result slot frees up when empty or being popped this cycle
  assign slot_free = !out_valid_q || pop;

  // Place lookup on the current remainder
  assign place       = place_find(rest_q);
  assign rest_sub    = rest_q - place_weight(place);
  assign pair_letter = place_second(place);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i && slot_free && !item_i.zero) begin
          state_d = ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (slot_free) begin
          if (pair_letter != ChNone) begin
            state_d = ST_SECOND;
          end else if (rest_sub == '0) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SECOND: begin
        if (slot_free) begin
          state_d = (rest_q == '0) ? ST_IDLE : ST_FIRST;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    item_take_o = 1'b0;
    emit        = 1'b0;
    rest_d      = rest_q;
    second_d    = second_q;
    letter_d    = letter_q;
    last_d      = last_q;
    empty_res_d = empty_res_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i && slot_free) begin
          item_take_o = 1'b1;
          rest_d      = item_i.value;
          if (item_i.zero) begin
            emit        = 1'b1;
            letter_d    = ChNone;
            last_d      = 1'b1;
            empty_res_d = 1'b1;
          end
        end
      end
      ST_FIRST: begin
        if (slot_free) begin
          emit        = 1'b1;
          rest_d      = rest_sub;
          second_d    = pair_letter;
          letter_d    = place_first(place);
          last_d      = (pair_letter == ChNone) && (rest_sub == '0);
          empty_res_d = 1'b0;
        end
      end
      ST_SECOND: begin
        if (slot_free) begin
          emit        = 1'b1;
          letter_d    = second_q;
          last_d      = (rest_q == '0);
          empty_res_d = 1'b0;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold remainder, pending pair letter and the result beat
  always_ff @(posedge clk_i) begin
    rest_q      <= rest_d;
    second_q    <= second_d;
    letter_q    <= letter_d;
    last_q      <= last_d;
    empty_res_q <= empty_res_d;
  end

  assign empty       = !out_valid_q;
  assign letter_o    = letter_q;
  assign last_o      = last_q;
  assign empty_res_o = empty_res_q;

endmodule

FILE: sv/integer_to_roman_numeral.sv
// ----------------------------------------------------------------------------
// integer_to_roman_numeral
// Spells a number as its Roman numeral, one ASCII letter per result beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: drive value_i and raise push; the beat
//   is taken on a clock edge with push high and full low.
//   Result side is a queue read port: while empty is low, letter_o, last_o
//   and empty_res_o show the oldest letter; pop on a cycle with empty low
//   takes it. last_o marks the final letter of a numeral. A zero value gives
//   one beat with letter_o = 0, last_o = 1 and empty_res_o = 1.
// Timing:
//   The first letter of a nonzero value goes from the input queue through
//   the sequencer's load step (ST_IDLE) and ST_FIRST into the result register
//   (a zero goes from ST_IDLE straight to it). The sequencer loads a value,
//   then emits its letters in turn, waiting while the result register holds
//   an unpopped letter; the sustained rate is set by that sequencer.
//   A short input queue (QueueDepth beats) keeps accepting while a result
//   waits; when pop stays low the result register holds and the queue fills.
// Reset:
//   rst_ni clears the queue, the sequencer and the result register.
// ----------------------------------------------------------------------------
module integer_to_roman_numeral #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [i2r_pkg::ValueW-1:0]  value_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [i2r_pkg::LetterW-1:0] letter_o,
  output logic                        last_o,
  output logic                        empty_res_o
);
  import i2r_pkg::*;

  logic      item_valid;
  logic      item_take;
  i2r_item_t item;

  // Accept and classify
  i2r_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .value_i      (value_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  // Spell letters
  i2r_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .empty        (empty),
    .pop          (pop),
    .letter_o     (letter_o),
    .last_o       (last_o),
    .empty_res_o  (empty_res_o)
  );

  `include "assert_macros.svh"

  `ASSERT_IMP(a_empty_res_form, !empty && empty_res_o,
              last_o && (letter_o == ChNone), "empty result malformed")
  `ASSERT_IMP(a_letter_nonzero, !empty && !empty_res_o,
              letter_o != ChNone, "letter beat without a letter")
  `ASSERT_IMP(a_full_has_item, full, item_valid, "queue full but no item offered")
  `ASSERT_NXT(a_zero_item_emits, item_take && item.zero,
              !empty && empty_res_o, "zero item gave no empty result")

endmodule
